// File: hdl/mlqd_pkg.sv
package mlqd_pkg;

	localparam int QueueDepthDefault = 16;
	localparam int NumQueues = 4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_ZERO     = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef enum logic {
		OP_ARRIVE   = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	// command handed from the front part to the back part
	typedef struct packed {
		logic        op;
		logic [1:0]  tq;
		logic [7:0]  id;
		logic [15:0] burst;
		logic [15:0] slice;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  rid;
		logic [1:0]  rq;
		logic [15:0] rtime;
		logic        fin;
		logic [31:0] tnow;
	} res_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_SCAN,
		B_SHIFT,
		B_TAIL,
		B_DONE
	} bstate_t;

endpackage

// File: hdl/multilevel_queue_dispatcher_core.sv
// Multilevel queue dispatcher: four fixed-priority job queues of QUEUE_DEPTH
// entries held in one RAM pair. A two-entry command queue takes the input
// transfers and sits in front of the scheduler. An arrive item, or a
// dispatch with every queue empty, passes the scheduler through its read and
// done states only. A dispatch reads the chosen queue once to pick a job,
// then, when the job finishes or comes from queue 0, moves the later entries
// down one place, and writes an unfinished job back; the scan and the shift
// share the one read address of the RAM pair. One result register holds the
// result until it is popped, and no new command starts before that.
module multilevel_queue_dispatcher_core #(
	parameter int QUEUE_DEPTH = mlqd_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [1:0]  target_queue,
	input  logic [7:0]  job_id,
	input  logic [15:0] burst,
	input  logic [15:0] slice_len,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [7:0]  run_id,
	output logic [1:0]  run_queue,
	output logic [15:0] run_time,
	output logic        finished,
	output logic [31:0] time_now
);

	mlqd_pkg::cmd_t in_cmd, cmd;
	mlqd_pkg::res_t res;
	logic           cq_empty, take, rv;

	assign in_cmd = '{op: op, tq: target_queue, id: job_id, burst: burst,
		slice: slice_len};

	mlqd_fifo #(.Width($bits(mlqd_pkg::cmd_t))) u_front (
		.clk, .arst_n, .wr(push), .wdata(in_cmd), .full,
		.rd(take), .rdata(cmd), .empty(cq_empty));

	mlqd_back #(.QueueDepth(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .cmd_valid(!cq_empty), .cmd, .cmd_take(take),
		.res_valid(rv), .res, .res_take(pop));

	assign empty     = !rv;
	assign status    = res.status;
	assign run_id    = res.rid;
	assign run_queue = res.rq;
	assign run_time  = res.rtime;
	assign finished  = res.fin;
	assign time_now  = res.tnow;

	// a finished run never reports zero time
	a_fin_time: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && finished) |-> run_time != 16'd0) else $error("fin zero");
	// a status other than ok never reports run time
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != mlqd_pkg::ST_OK) |-> run_time == 16'd0)
		else $error("err run");

endmodule

// File: hdl/mlqd_ram.sv
module mlqd_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write one entry, read one registered
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/mlqd_fifo.sv
module mlqd_fifo #(
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [Width-1:0] rdata,
	output logic             empty
);

	// two-entry queue
	logic [Width-1:0] d_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = d_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) d_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end

endmodule

// File: hdl/mlqd_back.sv
module mlqd_back #(
	parameter int QueueDepth = mlqd_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  mlqd_pkg::cmd_t cmd,
	output logic           cmd_take,
	output logic           res_valid,
	output mlqd_pkg::res_t res,
	input  logic           res_take
);

	localparam int PW = $clog2(QueueDepth);
	localparam int AW = PW + 2;
	localparam int LW = $clog2(QueueDepth + 1);
	localparam int KW = $clog2(QueueDepth + 2);

	mlqd_pkg::bstate_t state_q, state_d;

	logic [LW-1:0] len_q [mlqd_pkg::NumQueues];
	logic [8:0]    last_q;
	logic [31:0]   time_q;
	mlqd_pkg::cmd_t cmd_q;
	mlqd_pkg::res_t res_q;
	logic          rv_q;

	logic [1:0]    q_q;
	logic [KW-1:0] k_q;      // scan / shift read index
	logic [PW-1:0] pos_q;
	logic [15:0]   best_q;
	logic          seen_q, found_q;
	logic [7:0]    pid_q;
	logic [15:0]   prem_q;

	// memory ports
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wid, rid;
	logic [15:0]   wrem, rrem;

	logic [1:0]    selq;
	logic          any;
	logic [LW-1:0] curlen, arr_len;
	logic [KW-1:0] curlen_k, pos_k;
	logic [KW-1:0] kr;       // index of data arriving this cycle
	logic [KW-1:0] kr_dst;
	logic [15:0]   rt;
	logic [15:0]   nrem;
	logic          arrive, need_shift, scan_last, shift_last, res_set;
	mlqd_pkg::status_t arr_st;

	mlqd_ram #(.Width(8), .Depth(mlqd_pkg::NumQueues << PW)) u_ids (
		.clk, .we, .waddr, .wdata(wid), .raddr, .rdata(rid));
	mlqd_ram #(.Width(16), .Depth(mlqd_pkg::NumQueues << PW)) u_rem (
		.clk, .we, .waddr, .wdata(wrem), .raddr, .rdata(rrem));

	// highest-priority non-empty queue
	always_comb begin
		selq = 2'd0;
		any  = 1'b0;
		for (int i = mlqd_pkg::NumQueues - 1; i >= 0; i--) begin
			if (len_q[i] != '0) begin
				selq = 2'(i);
				any  = 1'b1;
			end
		end
	end

	assign curlen     = len_q[q_q];
	assign arr_len    = len_q[cmd_q.tq];
	assign curlen_k   = KW'(curlen);
	assign pos_k      = KW'(pos_q);
	assign kr         = k_q - KW'(1);
	assign kr_dst     = kr - KW'(1);
	assign rt         = (prem_q < cmd_q.slice) ? prem_q : cmd_q.slice;
	assign nrem       = prem_q - rt;
	assign arrive     = cmd_q.op == mlqd_pkg::OP_ARRIVE;
	assign need_shift = (q_q == 2'd0) || (nrem == 16'd0);
	assign scan_last  = (k_q == curlen_k + KW'(1)) || (q_q == 2'd3 && k_q == KW'(2));
	assign shift_last = kr >= curlen_k;

	// classify an arrival
	always_comb begin
		if (cmd_q.burst == 16'd0) arr_st = mlqd_pkg::ST_ZERO;
		else if (arr_len == LW'(QueueDepth)) arr_st = mlqd_pkg::ST_FULL;
		else arr_st = mlqd_pkg::ST_OK;
	end

	assign cmd_take  = state_q == mlqd_pkg::B_IDLE && cmd_valid && !rv_q;
	assign res_set   = (state_q == mlqd_pkg::B_READ && (arrive || !any))
		|| state_q == mlqd_pkg::B_TAIL;
	assign res_valid = rv_q;
	assign res       = res_q;

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = {cmd_q.tq, arr_len[PW-1:0]};
		wid     = cmd_q.id;
		wrem    = cmd_q.burst;
		raddr   = {q_q, k_q[PW-1:0]};
		case (state_q)
			mlqd_pkg::B_IDLE: if (cmd_take) state_d = mlqd_pkg::B_READ;
			mlqd_pkg::B_READ: begin
				// issue the read of the front entry of the chosen queue
				raddr = {selq, PW'(0)};
				if (arrive) begin
					we      = arr_st == mlqd_pkg::ST_OK;
					state_d = mlqd_pkg::B_DONE;
				end else if (!any) begin
					state_d = mlqd_pkg::B_DONE;
				end else begin
					state_d = mlqd_pkg::B_SCAN;
				end
			end
			mlqd_pkg::B_SCAN: begin
				if (scan_last)
					state_d = need_shift ? mlqd_pkg::B_SHIFT : mlqd_pkg::B_TAIL;
			end
			mlqd_pkg::B_SHIFT: begin
				// shift entries after pos down one place
				waddr = {q_q, kr_dst[PW-1:0]};
				wid   = rid;
				wrem  = rrem;
				we    = (kr > pos_k) && (kr < curlen_k);
				if (shift_last) state_d = mlqd_pkg::B_TAIL;
			end
			mlqd_pkg::B_TAIL: begin
				// write the unfinished job back: rear of queue 0, else in place
				waddr   = (q_q == 2'd0) ? {q_q, PW'(curlen - LW'(1))} : {q_q, pos_q};
				wid     = pid_q;
				wrem    = nrem;
				we      = nrem != 16'd0;
				state_d = mlqd_pkg::B_DONE;
			end
			mlqd_pkg::B_DONE: state_d = mlqd_pkg::B_IDLE;
			default: state_d = mlqd_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mlqd_pkg::B_IDLE;
		else state_q <= state_d;
	end

	// datapath and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mlqd_pkg::NumQueues; i++) len_q[i] <= '0;
			last_q  <= 9'h100;
			time_q  <= '0;
			rv_q    <= 1'b0;
			cmd_q   <= '0;
			res_q   <= '0;
			q_q     <= '0;
			k_q     <= '0;
			pos_q   <= '0;
			best_q  <= '0;
			seen_q  <= 1'b0;
			found_q <= 1'b0;
			pid_q   <= '0;
			prem_q  <= '0;
		end else begin
			// raise on a new result, drop on its transfer
			if (res_set) rv_q <= 1'b1;
			else if (res_take && rv_q) rv_q <= 1'b0;
			case (state_q)
				mlqd_pkg::B_IDLE: if (cmd_take) cmd_q <= cmd;
				mlqd_pkg::B_READ: begin
					q_q     <= selq;
					k_q     <= KW'(1);
					pos_q   <= '0;
					seen_q  <= 1'b0;
					found_q <= 1'b0;
					if (arrive) begin
						res_q <= '{status: arr_st, rid: '0, rq: '0, rtime: '0,
							fin: 1'b0, tnow: time_q};
						if (arr_st == mlqd_pkg::ST_OK)
							len_q[cmd_q.tq] <= arr_len + LW'(1);
					end else if (!any) begin
						res_q <= '{status: mlqd_pkg::ST_NONE, rid: '0, rq: '0,
							rtime: '0, fin: 1'b0, tnow: time_q};
					end
				end
				mlqd_pkg::B_SCAN: begin
					// data for entry kr arrives; issue read of k_q
					if (scan_last) begin
						if (need_shift) k_q <= pos_k + KW'(1);
					end else begin
						k_q <= k_q + KW'(1);
						if (kr == '0) begin
							pid_q  <= rid;
							prem_q <= rrem;
							best_q <= rrem;
							seen_q <= (q_q == 2'd0) && ({1'b0, rid} == last_q);
						end else if (q_q == 2'd0) begin
							if ({1'b0, rid} == last_q) begin
								seen_q <= 1'b1;
							end else if (seen_q && !found_q) begin
								found_q <= 1'b1;
								pos_q   <= PW'(kr);
								pid_q   <= rid;
								prem_q  <= rrem;
							end
						end else if (q_q != 2'd3 && rrem < best_q) begin
							best_q <= rrem;
							pos_q  <= PW'(kr);
							pid_q  <= rid;
							prem_q <= rrem;
						end
					end
				end
				mlqd_pkg::B_SHIFT: begin
					if (!shift_last) k_q <= k_q + KW'(1);
				end
				mlqd_pkg::B_TAIL: begin
					res_q <= '{status: mlqd_pkg::ST_OK, rid: pid_q, rq: q_q,
						rtime: rt, fin: nrem == 16'd0, tnow: time_q + 32'(rt)};
					time_q <= time_q + 32'(rt);
					if (nrem == 16'd0) len_q[q_q] <= curlen - LW'(1);
					if (q_q == 2'd0) last_q <= {1'b0, pid_q};
				end
				default: ;
			endcase
		end
	end

endmodule

// File: bench/mlqd_checker.sv
`timescale 1ns / 100ps

module mlqd_checker #(
	parameter int QUEUE_DEPTH = mlqd_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        op,
	input  logic [1:0]  target_queue,
	input  logic [7:0]  job_id,
	input  logic [15:0] burst,
	input  logic [15:0] slice_len,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [7:0]  run_id,
	input  logic [1:0]  run_queue,
	input  logic [15:0] run_time,
	input  logic        finished,
	input  logic [31:0] time_now,
	output int          errors,
	output int          pending
);

	typedef struct {
		mlqd_pkg::status_t st;
		logic [7:0]  rid;
		logic [1:0]  rq;
		logic [15:0] rtime;
		logic        fin;
		logic [31:0] tnow;
	} outcome_t;

	outcome_t outcomes_due[$];

	logic [7:0]  job_ids [mlqd_pkg::NumQueues][QUEUE_DEPTH];
	logic [15:0] job_left[mlqd_pkg::NumQueues][QUEUE_DEPTH];
	int          job_count[mlqd_pkg::NumQueues];
	logic [8:0]  last_rr;
	logic [31:0] clock_sum;

	assign pending = outcomes_due.size();

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		errors++;
	endtask

	// remove entry pos of queue q, closing the gap
	function automatic void remove_job(int q, int pos);
		for (int k = pos; k + 1 < job_count[q]; k++) begin
			job_ids[q][k]  = job_ids[q][k + 1];
			job_left[q][k] = job_left[q][k + 1];
		end
		job_count[q]--;
	endfunction

	// compute the outcome of one accepted command and update the queues
	function automatic outcome_t schedule(mlqd_pkg::op_t o, logic [1:0] tq,
			logic [7:0] id, logic [15:0] b, logic [15:0] sl);
		outcome_t r;
		int q;
		int pos;
		bit seen;
		logic [15:0] left;
		r = '{mlqd_pkg::ST_OK, 8'd0, 2'd0, 16'd0, 1'b0, 32'd0};
		if (o == mlqd_pkg::OP_ARRIVE) begin
			if (b == 0)
				r.st = mlqd_pkg::ST_ZERO;
			else if (job_count[tq] >= QUEUE_DEPTH)
				r.st = mlqd_pkg::ST_FULL;
			else begin
				job_ids[tq][job_count[tq]]  = id;
				job_left[tq][job_count[tq]] = b;
				job_count[tq]++;
			end
		end else begin
			q = 0;
			while (q < mlqd_pkg::NumQueues && job_count[q] == 0)
				q++;
			if (q >= mlqd_pkg::NumQueues)
				r.st = mlqd_pkg::ST_NONE;
			else begin
				pos = 0;
				if (q == 0) begin
					// round robin: first later entry with another id
					seen = 0;
					for (int k = 0; k < job_count[0]; k++) begin
						if ({1'b0, job_ids[0][k]} == last_rr)
							seen = 1;
						else if (seen) begin
							pos = k;
							break;
						end
					end
				end else if (q != 3) begin
					for (int k = 1; k < job_count[q]; k++)
						if (job_left[q][k] < job_left[q][pos])
							pos = k;
				end
				r.rid = job_ids[q][pos];
				left = job_left[q][pos];
				r.rtime = (left < sl) ? left : sl;
				left -= r.rtime;
				clock_sum += r.rtime;
				r.rq = 2'(q);
				r.fin = (left == 0);
				if (r.fin)
					remove_job(q, pos);
				else if (q == 0) begin
					remove_job(0, pos);
					job_ids[0][job_count[0]]  = r.rid;
					job_left[0][job_count[0]] = left;
					job_count[0]++;
				end else
					job_left[q][pos] = left;
				if (q == 0)
					last_rr = {1'b0, r.rid};
			end
		end
		r.tnow = clock_sum;
		return r;
	endfunction

	// predict on input transfers, compare on result transfers
	always @(posedge clk) begin
		outcome_t e;
		if (!arst_n) begin
			errors = 0;
			outcomes_due.delete();
			for (int q = 0; q < mlqd_pkg::NumQueues; q++)
				job_count[q] = 0;
			last_rr = 9'h100;
			clock_sum = '0;
		end else begin
			if (push && !full)
				outcomes_due.push_back(schedule(mlqd_pkg::op_t'(op), target_queue,
					job_id, burst, slice_len));
			if (pop && !empty) begin
				if (outcomes_due.size() == 0)
					report("result with nothing expected");
				else begin
					e = outcomes_due.pop_front();
					if (status !== e.st)
						report($sformatf("status %0d, want %0d", status, e.st));
					if (run_id !== e.rid)
						report($sformatf("run_id %0d, want %0d", run_id, e.rid));
					if (run_queue !== e.rq)
						report($sformatf("run_queue %0d, want %0d", run_queue, e.rq));
					if (run_time !== e.rtime)
						report($sformatf("run_time %0d, want %0d", run_time, e.rtime));
					if (finished !== e.fin)
						report($sformatf("finished %0d, want %0d", finished, e.fin));
					if (time_now !== e.tnow)
						report($sformatf("time_now %0d, want %0d", time_now, e.tnow));
				end
			end
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = mlqd_pkg::QueueDepthDefault;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        op;
	logic [1:0]  target_queue;
	logic [7:0]  job_id;
	logic [15:0] burst;
	logic [15:0] slice_len;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [7:0]  run_id;
	logic [1:0]  run_queue;
	logic [15:0] run_time;
	logic        finished;
	logic [31:0] time_now;
	int          errors;
	int          pending;

	multilevel_queue_dispatcher_core #(.QUEUE_DEPTH(DEPTH)) dut (.*);

	mlqd_checker #(.QUEUE_DEPTH(DEPTH)) checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hold the run to a fixed ceiling
	initial begin
		#20ms;
		$display("testbench: done, errors");
		$finish;
	end

	// hand one command over, then wait for its transfer
	task automatic send(mlqd_pkg::op_t o, logic [1:0] tq, logic [7:0] id,
			logic [15:0] b, logic [15:0] sl);
		push <= 1'b1;
		op <= o;
		target_queue <= tq;
		job_id <= id;
		burst <= b;
		slice_len <= sl;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		push <= 1'b0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	// random burst value: mostly small so jobs finish, sometimes extreme
	function automatic logic [15:0] rand_burst();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [15:0] rand_slice();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 20));
		endcase
	endfunction

	// receiver: stall on its own pattern, with calm stretches
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0)
				pop <= ($urandom_range(0, 1) == 0);
			else if ($urandom_range(0, 5) == 0)
				pop <= 1'b1;
		end
	end

	initial begin
		int left;
		push = 0;
		op = mlqd_pkg::OP_ARRIVE;
		target_queue = 0;
		job_id = 0;
		burst = 0;
		slice_len = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (3) @(negedge clk);

		// directed: empty dispatch, zero burst, extremes, each queue level
		send(mlqd_pkg::OP_DISPATCH, 2'd0, 8'd0, 16'd0, 16'hffff);
		send(mlqd_pkg::OP_ARRIVE, 2'd3, 8'hff, 16'd0, 16'd0);
		send(mlqd_pkg::OP_ARRIVE, 2'd3, 8'h00, 16'hffff, 16'hffff);
		send(mlqd_pkg::OP_ARRIVE, 2'd2, 8'h11, 16'd5, 16'd0);
		send(mlqd_pkg::OP_ARRIVE, 2'd2, 8'h12, 16'd3, 16'd0);
		send(mlqd_pkg::OP_ARRIVE, 2'd2, 8'h13, 16'd3, 16'd0);
		send(mlqd_pkg::OP_ARRIVE, 2'd1, 8'hff, 16'd1, 16'd0);
		send(mlqd_pkg::OP_ARRIVE, 2'd0, 8'h07, 16'd4, 16'd0);
		send(mlqd_pkg::OP_ARRIVE, 2'd0, 8'h08, 16'd2, 16'd0);
		send(mlqd_pkg::OP_DISPATCH, 2'd3, 8'hff, 16'hffff, 16'd0);
		send(mlqd_pkg::OP_DISPATCH, 2'd0, 8'd0, 16'd0, 16'd1);
		send(mlqd_pkg::OP_DISPATCH, 2'd0, 8'd0, 16'd0, 16'hffff);
		send(mlqd_pkg::OP_DISPATCH, 2'd0, 8'd0, 16'd0, 16'hffff);
		for (int k = 0; k < 6; k++)
			send(mlqd_pkg::OP_DISPATCH, 2'd0, 8'd0, 16'd0, 16'd2);
		// fill queue 3 past capacity
		for (int k = 0; k <= DEPTH; k++)
			send(mlqd_pkg::OP_ARRIVE, 2'd3, 8'(k), 16'hfffe, 16'd0);
		send(mlqd_pkg::OP_DISPATCH, 2'd0, 8'd0, 16'd0, 16'hffff);
		push <= 1'b0;

		// random: bursts of commands, with arrivals at 52 percent
		left = 1900;
		while (left > 0) begin
			repeat ($urandom_range(1, 30)) begin
				if (left > 0) begin
					if ($urandom_range(0, 99) < 52)
						send(mlqd_pkg::OP_ARRIVE, 2'($urandom),
							($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) :
							8'($urandom), rand_burst(), 16'($urandom));
					else
						send(mlqd_pkg::OP_DISPATCH, 2'($urandom), 8'($urandom),
							16'($urandom), rand_slice());
					left--;
				end
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender();
		end
		push <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 20) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
hdl/mlqd_pkg.sv
hdl/mlqd_ram.sv
hdl/mlqd_fifo.sv
hdl/mlqd_back.sv
hdl/multilevel_queue_dispatcher_core.sv
bench/mlqd_checker.sv
bench/testbench.sv
